@@ sv/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants, command codes and types of the stack calculator.
// ----------------------------------------------------------------------------
`default_nettype none
package rpn_pkg;
   localparam int DefStackDepth = 64;
   localparam int DefValueWidth = 32;
   localparam int DefFracBits   = 16;
   localparam int CmdWidth      = 3;

   typedef enum logic [CmdWidth-1:0] {
      CMD_PUSH  = 3'd0,
      CMD_ADD   = 3'd1,
      CMD_SUB   = 3'd2,
      CMD_MUL   = 3'd3,
      CMD_DIV   = 3'd4,
      CMD_MOD   = 3'd5,
      CMD_PRINT = 3'd6,
      CMD_UNK   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_DIV = 2'd1,
      OP_MOD = 2'd2
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_ctl_type;
endpackage
`default_nettype wire

@@ sv/rpn_if.sv @@
// ----------------------------------------------------------------------------
// RPN calculator channels
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface rpn_req_if #(parameter int VW = 32) (input wire logic clock);
   logic          valid;
   logic          ready;
   logic [2:0]    cmd;
   logic [VW-1:0] operand_value;
   modport source (output valid, cmd, operand_value, input ready);
   modport sink (input valid, cmd, operand_value, output ready);
endinterface

interface rpn_rsp_if #(parameter int VW = 32) (input wire logic clock);
   logic          valid;
   logic          ready;
   logic [VW-1:0] printed_value;
   logic          printed_valid;
   logic          err_stack_full;
   logic          err_stack_empty;
   logic          err_zero_divide;
   logic          err_unknown_cmd;
   modport source (output valid, printed_value, printed_valid, err_stack_full,
                   err_stack_empty, err_zero_divide, err_unknown_cmd, input ready);
   modport sink (input valid, printed_value, printed_valid, err_stack_full,
                 err_stack_empty, err_zero_divide, err_unknown_cmd, output ready);
endinterface
`default_nettype wire

@@ sv/rpn_alu.sv @@
// ----------------------------------------------------------------------------
// RPN serial arithmetic unit
// Shift-add multiplier and restoring divider on magnitudes, one bit a cycle,
// with saturation of the signed result.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_alu #(
   parameter int VALUE_WIDTH = rpn_pkg::DefValueWidth,
   parameter int FRAC_BITS   = rpn_pkg::DefFracBits
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rpn_pkg::alu_ctl_type     ctl,
   input  wire logic [VALUE_WIDTH-1:0]   a,
   input  wire logic [VALUE_WIDTH-1:0]   b,
   output logic                          done,
   output logic [VALUE_WIDTH-1:0]        result
);
   import rpn_pkg::*;

   localparam int VW  = VALUE_WIDTH;
   localparam int PW  = 2 * VW;           // product / dividend width
   localparam int QW  = VW + FRAC_BITS;   // dividend bits for divide
   localparam int CW  = $clog2(PW + 1);
   localparam logic [VW-1:0] MaxPos = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] MinNeg = {1'b1, {(VW-1){1'b0}}};

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   op_type        op_ff, op_in;
   logic          neg_ff, neg_in;
   logic [PW-1:0] acc_ff, acc_in;    // product or quotient
   logic [PW-1:0] sh_ff, sh_in;      // shifted multiplicand or dividend
   logic [VW-1:0] mb_ff, mb_in;      // multiplier bits or divisor
   logic [VW:0]   rem_ff, rem_in;
   logic          done_ff, done_in;
   logic [VW-1:0] res_ff, res_in;

   logic [VW-1:0] ma, mb;
   logic [VW:0]   rtry;
   logic [VW:0]   rdiff;
   logic [PW-1:0] mag;
   logic [PW-1:0] sum;

   assign ma = a[VW-1] ? (~a + 1'b1) : a;
   assign mb = b[VW-1] ? (~b + 1'b1) : b;
   assign rtry  = {rem_ff[VW-1:0], sh_ff[PW-1]};
   assign rdiff = rtry - {1'b0, mb_ff};
   assign sum   = acc_ff + sh_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      mb_in   = mb_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      mag     = acc_ff >> ((op_ff == OP_MUL) ? FRAC_BITS : 0);
      if (ctl.start && !busy_ff) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         acc_in  = '0;
         rem_in  = '0;
         unique case (ctl.op)
            OP_MUL: begin
               neg_in = a[VW-1] ^ b[VW-1];
               sh_in  = PW'(ma);
               mb_in  = mb;
               cnt_in = CW'(VW);
            end
            OP_DIV: begin
               // The magnitude sits at the top, followed by the fraction zeros.
               neg_in = a[VW-1] ^ b[VW-1];
               sh_in  = PW'(ma) << (PW - VW);
               mb_in  = mb;
               cnt_in = CW'(QW);
            end
            default: begin
               neg_in = a[VW-1];
               sh_in  = PW'(ma >> FRAC_BITS) << (PW - VW);
               mb_in  = mb >> FRAC_BITS;
               cnt_in = CW'(VW);
            end
         endcase
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
            if (op_ff == OP_MUL) begin
               if (mb_ff[0]) acc_in = sum;
               sh_in = sh_ff << 1;
               mb_in = mb_ff >> 1;
            end else begin
               sh_in = sh_ff << 1;
               if (!rdiff[VW]) begin
                  rem_in = rdiff;
                  acc_in = {acc_ff[PW-2:0], 1'b1};
               end else begin
                  rem_in = rtry;
                  acc_in = {acc_ff[PW-2:0], 1'b0};
               end
            end
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (op_ff == OP_MOD) begin
               mag    = PW'(rem_ff[VW-1:0]) << FRAC_BITS;
               res_in = neg_ff ? (~mag[VW-1:0] + 1'b1) : mag[VW-1:0];
            end else if (!neg_ff) begin
               res_in = (mag > PW'(MaxPos)) ? MaxPos : mag[VW-1:0];
            end else begin
               res_in = (mag > PW'(MinNeg)) ? MinNeg : (~mag[VW-1:0] + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      mb_ff  <= mb_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

@@ sv/rpn_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// RPN stack calculator
// Command sequencer with operand stack memory and a serial arithmetic unit.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the req channel (cmd, operand_value). Each
// request produces exactly one response on the rsp channel carrying the
// printed value and the error flags.
// One request is handled at a time. Push and unknown commands go straight
// to the response; the others pop b, then print it or check for a zero
// divisor, or else pop a and compute: add and subtract directly, multiply,
// divide and modulo in the serial arithmetic unit (Q16.16 by default). An
// empty stack shortens the walk. The walk is paced by the arithmetic unit,
// which works one bit per cycle, and by the single read port of the stack
// memory, read once per pop.
// The next request is taken as soon as the response sits in the output
// register, even if the receiver has not yet taken it; a stalled receiver
// holds the response and, after that, stops further requests.
// Reset empties the stack (count cleared); stack contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = rpn_pkg::DefStackDepth,
   parameter int VALUE_WIDTH = rpn_pkg::DefValueWidth,
   parameter int FRAC_BITS   = rpn_pkg::DefFracBits
) (
   input wire logic clock,
   input wire logic reset,
   rpn_req_if.sink  req,
   rpn_rsp_if.source rsp
);
   import rpn_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int NW = $clog2(STACK_DEPTH + 1);
   localparam logic [VW-1:0] MaxPos = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] MinNeg = {1'b1, {(VW-1){1'b0}}};

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_POPB  = 8'b0000_0010,
      ST_WAITB = 8'b0000_0100,
      ST_POPA  = 8'b0000_1000,
      ST_WAITA = 8'b0001_0000,
      ST_EXEC  = 8'b0010_0000,
      ST_ALU   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [NW-1:0] count_ff, count_in;
   cmd_type       cmd_ff, cmd_in;
   logic [VW-1:0] opv_ff, opv_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in;
   logic          empty_ff, empty_in, zdiv_ff, zdiv_in;
   logic          rvalid_ff, rvalid_in;
   logic [VW-1:0] rval_ff, rval_in;
   logic          rpv_ff, rpv_in, rfull_ff, rfull_in, rempty_ff, rempty_in;
   logic          rzd_ff, rzd_in, runk_ff, runk_in;

   logic [VW-1:0] mem [STACK_DEPTH];
   logic [VW-1:0] rd_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;

   alu_ctl_type   alu_ctl;
   logic          alu_done;
   logic [VW-1:0] alu_res;
   logic [VW:0]   ext_sum, ext_dif;
   logic [VW-1:0] bint;
   logic          push_now;
   logic [VW-1:0] push_val;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   rpn_alu #(.VALUE_WIDTH(VW), .FRAC_BITS(FRAC_BITS)) u_alu (
      .clock(clock), .reset(reset), .ctl(alu_ctl), .a(a_ff), .b(b_ff),
      .done(alu_done), .result(alu_res)
   );

   assign ext_sum = {a_ff[VW-1], a_ff} + {b_ff[VW-1], b_ff};
   assign ext_dif = {a_ff[VW-1], a_ff} - {b_ff[VW-1], b_ff};
   assign bint    = (b_ff[VW-1] ? (~b_ff + 1'b1) : b_ff) >> FRAC_BITS;
   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd_in    = cmd_ff;
      opv_in    = opv_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      empty_in  = empty_ff;
      zdiv_in   = zdiv_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      rval_in   = rval_ff;
      rpv_in    = rpv_ff;
      rfull_in  = rfull_ff;
      rempty_in = rempty_ff;
      rzd_in    = rzd_ff;
      runk_in   = runk_ff;
      rd_en     = 1'b0;
      rd_addr   = AW'(count_ff - 1'b1);
      wr_en     = 1'b0;
      wr_addr   = AW'(count_ff);
      wr_data   = opv_ff;
      alu_ctl.start = 1'b0;
      alu_ctl.op    = OP_MUL;
      push_now  = 1'b0;
      push_val  = opv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in   = cmd_type'(req.cmd);
               opv_in   = req.operand_value;
               a_in     = '0;
               b_in     = '0;
               empty_in = 1'b0;
               zdiv_in  = 1'b0;
               state_in = (cmd_type'(req.cmd) == CMD_PUSH
                           || cmd_type'(req.cmd) == CMD_UNK) ? ST_DONE : ST_POPB;
            end
         end
         ST_POPB: begin
            if (count_ff == '0) begin
               empty_in = 1'b1;
               b_in     = '0;
               state_in = ST_EXEC;
            end else begin
               rd_en    = 1'b1;
               count_in = count_ff - 1'b1;
               state_in = ST_WAITB;
            end
         end
         ST_WAITB: begin
            b_in     = rd_ff;
            state_in = ST_EXEC;
         end
         ST_POPA: begin
            if (count_ff == '0) begin
               empty_in = 1'b1;
               a_in     = '0;
               state_in = ST_EXEC;
            end else begin
               rd_en    = 1'b1;
               count_in = count_ff - 1'b1;
               state_in = ST_WAITA;
            end
         end
         ST_WAITA: begin
            a_in     = rd_ff;
            state_in = ST_ALU;
         end
         ST_EXEC: begin
            // Reached after popping b (print, zero checks) or after an empty pop of a.
            state_in = ST_DONE;
            if (cmd_ff == CMD_PRINT) begin
               opv_in = b_ff;
            end else if (cmd_ff == CMD_DIV && b_ff == '0) begin
               zdiv_in = 1'b1;
            end else if (cmd_ff == CMD_MOD && bint == '0) begin
               zdiv_in = 1'b1;
            end else begin
               state_in = ST_POPA;
               if (empty_ff && count_ff == '0) begin
                  // second pop is also empty, a stays zero
                  state_in = ST_ALU;
               end
            end
         end
         ST_ALU: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  push_now = 1'b1;
                  push_val = (ext_sum[VW] != ext_sum[VW-1])
                             ? (ext_sum[VW] ? MinNeg : MaxPos) : ext_sum[VW-1:0];
               end
               CMD_SUB: begin
                  push_now = 1'b1;
                  push_val = (ext_dif[VW] != ext_dif[VW-1])
                             ? (ext_dif[VW] ? MinNeg : MaxPos) : ext_dif[VW-1:0];
               end
               default: begin
                  alu_ctl.start = 1'b1;
                  alu_ctl.op    = (cmd_ff == CMD_MUL) ? OP_MUL
                                : (cmd_ff == CMD_DIV) ? OP_DIV : OP_MOD;
                  if (alu_done) begin
                     alu_ctl.start = 1'b0;
                     push_now = 1'b1;
                     push_val = alu_res;
                  end
               end
            endcase
            if (push_now) begin
               opv_in   = push_val;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!(rvalid_ff && !rsp.ready)) begin
               rfull_in = 1'b0;
               if (cmd_ff != CMD_PRINT && cmd_ff != CMD_UNK && !zdiv_ff) begin
                  if (count_ff >= NW'(STACK_DEPTH)) begin
                     rfull_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = opv_ff;
                     count_in = count_ff + 1'b1;
                  end
               end
               rvalid_in = 1'b1;
               rpv_in    = (cmd_ff == CMD_PRINT);
               rval_in   = (cmd_ff == CMD_PRINT) ? opv_ff : '0;
               rempty_in = empty_ff;
               rzd_in    = zdiv_ff;
               runk_in   = (cmd_ff == CMD_UNK);
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
      cmd_ff    <= cmd_in;
      opv_ff    <= opv_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      empty_ff  <= empty_in;
      zdiv_ff   <= zdiv_in;
      rval_ff   <= rval_in;
      rpv_ff    <= rpv_in;
      rfull_ff  <= rfull_in;
      rempty_ff <= rempty_in;
      rzd_ff    <= rzd_in;
      runk_ff   <= runk_in;
   end

   assign rsp.valid           = rvalid_ff;
   assign rsp.printed_value   = rval_ff;
   assign rsp.printed_valid   = rpv_ff;
   assign rsp.err_stack_full  = rfull_ff;
   assign rsp.err_stack_empty = rempty_ff;
   assign rsp.err_zero_divide = rzd_ff;
   assign rsp.err_unknown_cmd = runk_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(STACK_DEPTH)) else $error("stack count out of range");
   a_idle_no_alu: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !alu_ctl.start) else $error("alu started while idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && !rsp.ready |=> rvalid_ff && $stable(rval_ff))
      else $error("response dropped under stall");
`endif
endmodule
`default_nettype wire
